[src/jcs_pkg.sv]
// ----------------------------------------------------------------------------
// jcs_pkg
// Types and character codes used by the comment stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_STRING = 4'b0010,
      MODE_LINE   = 4'b0100,
      MODE_BLOCK  = 4'b1000
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_word_type;

endpackage

[src/jcs_if.sv]
// ----------------------------------------------------------------------------
// jcs_if
// Valid/ready channels of the comment stripper: text in, stripped text out.
// ----------------------------------------------------------------------------
interface jcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

[src/json_comment_stripper.sv]
// ----------------------------------------------------------------------------
// json_comment_stripper
// Streams text through, removing line and block comments outside strings.
//
//   channel   dir  word                        notes
//   req_chan  in   in_byte, end_of_text        one text byte
//   rsp_chan  out  out_byte, run_last          0..2 words per input word
//
// One input word per cycle while the queue has room; the lexer update is one
// pass of compares between the input register and a 4-entry result queue.
// An accepted word goes to the input register, and its results then go to the
// result queue. A word that gives two results fills two queue entries; the queue
// takes an input word only while at least two entries are free.
// Reset is synchronous and returns the lexer to normal text, queue empty.
// ----------------------------------------------------------------------------
module json_comment_stripper
   import jcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jcs_req_if.sink    req_chan,
   jcs_rsp_if.source  rsp_chan
);

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        advance;
   logic        take;

   // lexer state
   lex_mode_type mode_ff, mode_in;
   logic         escape_ff, escape_in;
   logic         held_ff, held_in;
   logic         star_ff, star_in;

   // emitted words
   logic [1:0]   n_emit;
   rsp_word_type e0, e1;

   // result queue
   rsp_word_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   pop;

   assign advance         = s1_valid_ff && (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign req_chan.ready  = !s1_valid_ff || advance;
   assign take            = req_chan.valid && req_chan.ready;
   assign s1_valid_in     = take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_byte_ff <= req_chan.in_byte;
         s1_last_ff <= req_chan.end_of_text;
      end
   end

   always_comb begin
      logic [7:0] b;
      logic       done;
      b         = s1_byte_ff;
      done      = 1'b0;
      mode_in   = mode_ff;
      escape_in = escape_ff;
      held_in   = held_ff;
      star_in   = star_ff;
      n_emit    = 2'd0;
      e0        = '{out_byte: b, run_last: 1'b0};
      e1        = '{out_byte: b, run_last: 1'b0};

      case (mode_ff)
         MODE_LINE: begin
            if (b == CH_NL) begin
               mode_in = MODE_NORMAL;
               n_emit  = 2'd1;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && b == CH_SLASH) begin
               mode_in = MODE_NORMAL;
               star_in = 1'b0;
            end else begin
               star_in = (b == CH_STAR);
               if (b == CH_NL) begin
                  n_emit = 2'd1;
               end
            end
         end
         MODE_STRING: begin
            n_emit = 2'd1;
            if (escape_ff) begin
               escape_in = 1'b0;
            end else if (b == CH_BSLASH) begin
               escape_in = 1'b1;
            end else if (b == CH_QUOTE) begin
               mode_in = MODE_NORMAL;
            end
         end
         default: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (b == CH_SLASH) begin
                  mode_in = MODE_LINE;
                  done    = 1'b1;
               end else if (b == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  star_in = 1'b0;
                  done    = 1'b1;
               end else begin
                  e0.out_byte = CH_SLASH;
                  n_emit      = 2'd1;
               end
            end
            if (!done) begin
               if (b == CH_SLASH) begin
                  held_in = 1'b1;
               end else begin
                  if (b == CH_QUOTE) begin
                     mode_in   = MODE_STRING;
                     escape_in = 1'b0;
                  end
                  if (n_emit == 2'd0) begin
                     e0.out_byte = b;
                  end else begin
                     e1.out_byte = b;
                  end
                  n_emit = n_emit + 2'd1;
               end
            end
         end
      endcase

      if (s1_last_ff) begin
         if (held_in) begin
            if (n_emit == 2'd0) begin
               e0.out_byte = CH_SLASH;
            end else begin
               e1.out_byte = CH_SLASH;
            end
            n_emit = n_emit + 2'd1;
         end
         mode_in   = MODE_NORMAL;
         escape_in = 1'b0;
         held_in   = 1'b0;
         star_in   = 1'b0;
      end

      if (n_emit == 2'd1) begin
         e0.run_last = 1'b1;
      end
      if (n_emit == 2'd2) begin
         e1.run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         escape_ff <= 1'b0;
         held_ff   <= 1'b0;
         star_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
         held_ff   <= held_in;
         star_ff   <= star_in;
      end
   end

   // result queue
   assign pop               = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid    = (count_ff != '0);
   assign rsp_chan.out_byte = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.run_last = queue_ff[rd_ptr_ff].run_last;

   always_comb begin
      logic [1:0] n_push;
      n_push   = advance ? n_emit : 2'd0;
      count_in = count_ff - CNT_W'(pop) + CNT_W'(n_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (advance) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_emit);
         end
      end
      if (advance && n_emit != 2'd0) begin
         queue_ff[wr_ptr_ff] <= e0;
      end
      if (advance && n_emit == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= e1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && !s1_valid_ff)
      else $error("queue not empty after reset");

   a_held_normal: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (mode_ff == MODE_NORMAL))
      else $error("slash held outside normal text");

   a_star_block: assert property (@(posedge clock) disable iff (reset)
      star_ff |-> (mode_ff == MODE_BLOCK))
      else $error("star flag outside block comment");

   a_escape_string: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (mode_ff == MODE_STRING))
      else $error("escape pending outside string");

endmodule
